FILE: design/spdf_pkg.sv
package spdf_pkg;

	localparam logic [16:0] POS_MAX    = 17'h1FFFF;
	localparam logic [16:0] HDR_BYTES  = 17'd6;
	localparam logic [16:0] CRC_START  = 17'd2;
	localparam logic [16:0] TRL_MIN    = 17'd9;
	localparam logic [16:0] LEN_BASE   = 17'd7;
	localparam logic [16:0] TRL_BYTES  = 17'd2;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR = 3'd1;
	localparam logic [2:0] ST_SHORT_TRL = 3'd2;
	localparam logic [2:0] ST_CRC_BAD   = 3'd3;
	localparam logic [2:0] ST_LEN_BAD   = 3'd4;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_RECORD  = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  version;
		logic        type_flag;
		logic        secondary_header;
		logic [10:0] apid;
		logic [1:0]  seg_flags;
		logic [13:0] seq_count;
		logic [15:0] data_length;
		logic [2:0]  status;
		logic [15:0] computed_crc;
	} record_t;

	typedef struct packed {
		logic       has_payload;
		logic [7:0] payload_byte;
		logic       has_record;
		record_t    rec;
	} entry_t;

	typedef struct packed {
		logic        record_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  version;
		logic        type_flag;
		logic        secondary_header;
		logic [10:0] apid;
		logic [1:0]  seg_flags;
		logic [13:0] seq_count;
		logic [15:0] data_length;
		logic [2:0]  status;
		logic [15:0] computed_crc;
	} out_item_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: design/spdf_front.sv
module spdf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  spdf_pkg::in_item_t in_item,
	input  logic               cfg_we,
	input  logic               cfg_data,
	output logic               entry_push,
	output spdf_pkg::entry_t   entry
);

	logic [16:0] pos_q;
	logic [47:0] hdr_q;
	logic [15:0] td_q;
	logic [15:0] crc_q;
	logic        trl_q;

	logic [47:0] hdr_next;
	logic [15:0] crc_next;
	logic [15:0] td_next;
	logic [15:0] len;
	logic [15:0] pid;
	logic [15:0] seq;
	logic [16:0] pos_inc;
	logic [16:0] off;
	logic [16:0] need;
	logic        in_payload;
	logic [2:0]  status;

	always_comb begin
		hdr_next = (pos_q < spdf_pkg::HDR_BYTES) ? {hdr_q[39:0], in_item.data_byte} : hdr_q;
		crc_next = (pos_q >= spdf_pkg::CRC_START) ? spdf_pkg::crc_feed(crc_q, td_q[15:8]) : crc_q;
		td_next  = {td_q[7:0], in_item.data_byte};
		len      = hdr_next[15:0];
		pid      = hdr_next[47:32];
		seq      = hdr_next[31:16];
		pos_inc  = (pos_q != spdf_pkg::POS_MAX) ? pos_q + 17'd1 : pos_q;
		off      = pos_q - spdf_pkg::HDR_BYTES;
		in_payload = (pos_q >= spdf_pkg::HDR_BYTES) && (pos_q != spdf_pkg::POS_MAX)
			&& (off <= {1'b0, len});
		need = spdf_pkg::LEN_BASE + {1'b0, len} + (trl_q ? spdf_pkg::TRL_BYTES : 17'd0);

		priority if (pos_inc < spdf_pkg::HDR_BYTES) begin
			status = spdf_pkg::ST_SHORT_HDR;
		end else if (trl_q && pos_inc < spdf_pkg::TRL_MIN) begin
			status = spdf_pkg::ST_SHORT_TRL;
		end else if (trl_q && crc_next != td_next) begin
			status = spdf_pkg::ST_CRC_BAD;
		end else if (pos_inc != need) begin
			status = spdf_pkg::ST_LEN_BAD;
		end else begin
			status = spdf_pkg::ST_OK;
		end

		entry = '0;
		entry.has_payload  = in_payload;
		entry.payload_byte = in_item.data_byte;
		entry.has_record   = in_item.end_of_buffer;
		if (status != spdf_pkg::ST_SHORT_HDR) begin
			entry.rec.version          = pid[15:13];
			entry.rec.type_flag        = pid[12];
			entry.rec.secondary_header = pid[11];
			entry.rec.apid             = pid[10:0];
			entry.rec.seg_flags        = seq[15:14];
			entry.rec.seq_count        = seq[13:0];
			entry.rec.data_length      = len;
		end
		entry.rec.status = status;
		if (trl_q && pos_inc >= spdf_pkg::TRL_MIN) begin
			entry.rec.computed_crc = crc_next;
		end

		entry_push = take && (in_payload || in_item.end_of_buffer);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
			td_q  <= '0;
			crc_q <= spdf_pkg::CRC_INIT;
			trl_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				trl_q <= cfg_data;
			end
			if (take) begin
				if (in_item.end_of_buffer) begin
					pos_q <= '0;
					hdr_q <= '0;
					td_q  <= '0;
					crc_q <= spdf_pkg::CRC_INIT;
				end else begin
					pos_q <= pos_inc;
					hdr_q <= hdr_next;
					td_q  <= td_next;
					crc_q <= crc_next;
				end
			end
		end
	end

endmodule

FILE: design/spdf_queue.sv
module spdf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  spdf_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             rd_en,
	output spdf_pkg::entry_t rd_entry,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	spdf_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(wr_en) - CW'(rd_en);
		end
	end

endmodule

FILE: design/spdf_back.sv
module spdf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  spdf_pkg::entry_t    head,
	input  logic                head_empty,
	output logic                head_pop,
	input  logic                pop,
	output logic                empty,
	output spdf_pkg::out_item_t out_item
);

	logic phase_q;
	logic show_payload;
	logic take;

	always_comb begin
		show_payload = head.has_payload && !phase_q;
		take         = pop && !head_empty;
		head_pop     = take && !(show_payload && head.has_record);
		empty        = head_empty;

		out_item = '0;
		if (show_payload) begin
			out_item.record_kind  = spdf_pkg::KIND_PAYLOAD;
			out_item.payload_byte = head.payload_byte;
		end else begin
			out_item.record_kind      = spdf_pkg::KIND_RECORD;
			out_item.version          = head.rec.version;
			out_item.type_flag        = head.rec.type_flag;
			out_item.secondary_header = head.rec.secondary_header;
			out_item.apid             = head.rec.apid;
			out_item.seg_flags        = head.rec.seg_flags;
			out_item.seq_count        = head.rec.seq_count;
			out_item.data_length      = head.rec.data_length;
			out_item.status           = head.rec.status;
			out_item.computed_crc     = head.rec.computed_crc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= !head_pop;
		end
	end

endmodule

FILE: design/space_packet_deframer_crc_check.sv
// Channel    Direction  Handshake            Transaction
// in_item    input      push / full          one buffer byte and its end mark
// cfg        input      cfg_valid/cfg_ready  trailer option bit
// out_item   output     empty / pop          payload byte or end-of-packet record
//
// The front end takes one byte per cycle while full is low and updates the header, CRC and
// counter at once. Results go through a queue of QUEUE_DEPTH entries, so the first result
// is visible in the cycle after the byte is taken. A byte that ends the buffer inside the
// payload takes two pops, which is the only case that drains slower than one byte per cycle
// while pop is high. Reset clears all control state and the trailer option; cfg_ready is
// always high. full is high only while the queue is full.
module space_packet_deframer_crc_check #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  spdf_pkg::in_item_t  in_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	output logic                empty,
	input  logic                pop,
	output spdf_pkg::out_item_t out_item
);

	logic             take;
	logic             entry_push;
	spdf_pkg::entry_t entry;
	spdf_pkg::entry_t head;
	logic             head_empty;
	logic             head_pop;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;

	spdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.in_item    (in_item),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.entry_push (entry_push),
		.entry      (entry)
	);

	spdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (entry_push),
		.wr_entry (entry),
		.full     (full),
		.rd_en    (head_pop),
		.rd_entry (head),
		.empty    (head_empty)
	);

	spdf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.out_item   (out_item)
	);

	a_split_record_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && out_item.record_kind == spdf_pkg::KIND_PAYLOAD && head.has_record)
		|=> (!empty && out_item.record_kind == spdf_pkg::KIND_RECORD))
		else $error("record lost after final payload byte");

	a_short_header_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.record_kind == spdf_pkg::KIND_RECORD
			&& out_item.status == spdf_pkg::ST_SHORT_HDR)
		|-> (out_item.apid == '0 && out_item.data_length == '0 && out_item.version == '0))
		else $error("short header record carries header fields");

	a_short_trailer_no_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.record_kind == spdf_pkg::KIND_RECORD
			&& out_item.status == spdf_pkg::ST_SHORT_TRL)
		|-> (out_item.computed_crc == '0))
		else $error("short trailer record carries a CRC");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("queue reports full and empty together");

endmodule

FILE: sim/space_packet_deframer_crc_check_test.sv
module space_packet_deframer_crc_check_test;
	import spdf_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE = 6;
	localparam int LONG_HOLD = 64;

	typedef enum logic [1:0] {STIM_BYTE, STIM_CFG, STIM_CALM} stim_kind_e;
	typedef enum int {TAIL_NONE, TAIL_GOOD, TAIL_BAD} tail_e;

	typedef struct {
		stim_kind_e kind;
		in_item_t   item;
		logic       opt;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  in_item = '0;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t out_item;

	stim_t     stim_q[$];
	out_item_t want_q[$];

	logic [16:0] pos_cnt = '0;
	logic [47:0] hdr_bits = '0;
	logic [15:0] crc_lag = '0;
	logic [15:0] crc_acc = CRC_INIT;
	logic        trailer_on = 1'b0;
	logic        plan_opt = 1'b0;

	bit calm = 1'b0;
	bit calm_seen = 1'b0;
	int open_results = 0;
	int idle_left = 0;
	int hold_left = 0;
	int holds_done = 0;
	int next_hold = 250;
	int quiet = 0;
	int planned_bytes = 0;
	int bytes_sent = 0;
	int opt_writes = 0;
	int results_seen = 0;
	int payload_seen = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int status_hits[0:4] = '{default: 0};

	space_packet_deframer_crc_check uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic logic [47:0] rand_hdr(input logic [15:0] len);
		return {16'($urandom), 16'($urandom), len};
	endfunction

	// Advances the deframer state by one byte and queues the results it must produce.
	task automatic deframe_byte(input logic [7:0] b, input logic last);
		logic [16:0] at;
		logic [15:0] len_f;
		logic [15:0] pid;
		logic [15:0] seq;
		logic [17:0] need;
		logic [2:0]  st;
		out_item_t   r;
		at = pos_cnt;
		if (at < HDR_BYTES) begin
			hdr_bits = {hdr_bits[39:0], b};
		end
		if (at >= CRC_START) begin
			crc_acc = crc16_step(crc_acc, crc_lag[15:8]);
		end
		crc_lag = {crc_lag[7:0], b};
		len_f = hdr_bits[15:0];
		if (at >= HDR_BYTES && at != POS_MAX && (at - HDR_BYTES) <= {1'b0, len_f}) begin
			r = '0;
			r.record_kind = KIND_PAYLOAD;
			r.payload_byte = b;
			want_q.insert(want_q.size(), r);
		end
		if (pos_cnt < POS_MAX) begin
			pos_cnt = pos_cnt + 17'd1;
		end
		if (last) begin
			pid = hdr_bits[47:32];
			seq = hdr_bits[31:16];
			need = 18'(LEN_BASE) + 18'(len_f) + (trailer_on ? 18'(TRL_BYTES) : 18'd0);
			if (pos_cnt < HDR_BYTES) begin
				st = ST_SHORT_HDR;
			end else if (trailer_on && pos_cnt < TRL_MIN) begin
				st = ST_SHORT_TRL;
			end else if (trailer_on && crc_acc != crc_lag) begin
				st = ST_CRC_BAD;
			end else if ({1'b0, pos_cnt} != need) begin
				st = ST_LEN_BAD;
			end else begin
				st = ST_OK;
			end
			r = '0;
			r.record_kind = KIND_RECORD;
			if (st != ST_SHORT_HDR) begin
				r.version = pid[15:13];
				r.type_flag = pid[12];
				r.secondary_header = pid[11];
				r.apid = pid[10:0];
				r.seg_flags = seq[15:14];
				r.seq_count = seq[13:0];
				r.data_length = len_f;
			end
			r.status = st;
			if (trailer_on && pos_cnt >= TRL_MIN) begin
				r.computed_crc = crc_acc;
			end
			want_q.insert(want_q.size(), r);
			pos_cnt = '0;
			hdr_bits = '0;
			crc_lag = '0;
			crc_acc = CRC_INIT;
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic last);
		stim_q.insert(stim_q.size(),
			'{kind: STIM_BYTE, item: '{data_byte: b, end_of_buffer: last}, opt: 1'b0});
		planned_bytes++;
	endtask

	task automatic add_cfg(input logic v);
		stim_q.insert(stim_q.size(), '{kind: STIM_CFG, item: '0, opt: v});
		plan_opt = v;
	endtask

	task automatic add_raw(input int n);
		for (int k = 0; k < n; k++) begin
			add_byte(8'($urandom), k == n - 1);
		end
	endtask

	// A flip_at of zero or more toggles the trailer option before that byte of the buffer.
	task automatic add_packet(input logic [47:0] hdr, input int body, input tail_e tail,
			input int flip_at);
		logic [7:0]  bytes[$];
		logic [15:0] acc;
		acc = CRC_INIT;
		for (int k = 5; k >= 0; k--) begin
			bytes.insert(bytes.size(), hdr[k*8 +: 8]);
		end
		repeat (body) bytes.insert(bytes.size(), 8'($urandom));
		foreach (bytes[k]) begin
			acc = crc16_step(acc, bytes[k]);
		end
		if (tail != TAIL_NONE) begin
			if (tail == TAIL_BAD) begin
				acc = acc ^ 16'(1 << $urandom_range(0, 15));
			end
			bytes.insert(bytes.size(), acc[15:8]);
			bytes.insert(bytes.size(), acc[7:0]);
		end
		foreach (bytes[k]) begin
			if (k == flip_at) begin
				add_cfg(!plan_opt);
			end
			add_byte(bytes[k], k == bytes.size() - 1);
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [127:0] want,
			input logic [127:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("Mismatch in %s at result %0d: expected %0h, got %0h",
				what, results_seen, want, got);
		end
	endtask

	task automatic check_field(input string what, input logic [127:0] want,
			input logic [127:0] got);
		if (got !== want) begin
			flag_mismatch(what, want, got);
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		open_results = want_q.size();
		calm_seen = calm;
	end

	always @(posedge clk or negedge arst_n) begin : drive
		logic nxt_push;
		logic nxt_cfg;
		if (!arst_n) begin
			push <= 1'b0;
			in_item <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= 1'b0;
			pos_cnt = '0;
			hdr_bits = '0;
			crc_lag = '0;
			crc_acc = CRC_INIT;
			trailer_on = 1'b0;
			idle_left = 0;
			quiet = 0;
		end else begin
			nxt_push = push;
			nxt_cfg = cfg_valid;
			quiet = (open_results == 0) ? quiet + 1 : 0;
			if (push && !full) begin
				deframe_byte(in_item.data_byte, in_item.end_of_buffer);
				bytes_sent++;
				nxt_push = 1'b0;
				quiet = 0;
			end
			if (cfg_valid && cfg_ready) begin
				trailer_on = cfg_data;
				opt_writes++;
				nxt_cfg = 1'b0;
			end
			if (nxt_push || nxt_cfg) begin
				idle_left = idle_left;
			end else if (idle_left > 0) begin
				idle_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				idle_left = $urandom_range(0, 2);
			end else if (stim_q.size() != 0) begin
				case (stim_q[0].kind)
					STIM_BYTE: begin
						in_item <= stim_q[0].item;
						nxt_push = 1'b1;
						stim_q.delete(0);
					end
					STIM_CFG: begin
						if (quiet >= SETTLE) begin
							cfg_data <= stim_q[0].opt;
							nxt_cfg = 1'b1;
							stim_q.delete(0);
						end
					end
					STIM_CALM: begin
						calm = 1'b1;
						stim_q.delete(0);
					end
					default: begin
						stim_q.delete(0);
					end
				endcase
			end
			push <= nxt_push;
			cfg_valid <= nxt_cfg;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results_seen++;
				if (want_q.size() == 0) begin
					flag_mismatch("transaction with nothing expected", '0, out_item);
				end else begin
					want = want_q.pop_front();
					check_field("record_kind", want.record_kind, out_item.record_kind);
					check_field("payload_byte", want.payload_byte, out_item.payload_byte);
					check_field("version", want.version, out_item.version);
					check_field("type_flag", want.type_flag, out_item.type_flag);
					check_field("secondary_header", want.secondary_header,
						out_item.secondary_header);
					check_field("apid", want.apid, out_item.apid);
					check_field("seg_flags", want.seg_flags, out_item.seg_flags);
					check_field("seq_count", want.seq_count, out_item.seq_count);
					check_field("data_length", want.data_length, out_item.data_length);
					check_field("status", want.status, out_item.status);
					check_field("computed_crc", want.computed_crc, out_item.computed_crc);
					if (want.record_kind == KIND_RECORD) begin
						status_hits[want.status]++;
					end else begin
						payload_seen++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!calm_seen && holds_done < 2 && results_seen >= next_hold) begin
				holds_done++;
				next_hold += 400;
				hold_left = LONG_HOLD - 1;
				pop <= 1'b0;
			end else if (!calm_seen && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 2);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, want_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int    len;
		int    body;
		int    pick;
		int    stop_at;
		int    next_phase;
		tail_e tail;

		add_cfg(1'b0);
		add_byte(8'hFF, 1'b1);
		add_packet(48'h0, 0, TAIL_NONE, -1);
		add_cfg(1'b1);
		add_packet(rand_hdr(16'd0), 0, TAIL_GOOD, -1);
		add_packet({32'hFFFF_FFFF, 16'd0}, 1, TAIL_GOOD, -1);
		add_packet(rand_hdr(16'd0), 1, TAIL_GOOD, 4);

		stop_at = planned_bytes + 1050;
		next_phase = planned_bytes;
		while (planned_bytes < stop_at) begin
			if (planned_bytes >= next_phase) begin
				add_cfg(!plan_opt);
				next_phase = planned_bytes + $urandom_range(80, 180);
			end
			pick = $urandom_range(0, 99);
			len = (pick < 10) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			tail = plan_opt ? (($urandom_range(0, 9) == 0) ? TAIL_BAD : TAIL_GOOD) : TAIL_NONE;
			if (pick < 72) begin
				add_packet(rand_hdr(16'(len)), len + 1, tail, -1);
			end else if (pick < 84) begin
				body = $urandom_range(0, len + 4);
				if (body == len + 1) begin
					body = len + 2;
				end
				add_packet(rand_hdr(16'(len)), body, tail, -1);
			end else if (pick < 90) begin
				add_packet(rand_hdr(16'($urandom)), $urandom_range(0, 10), tail, -1);
			end else if (pick < 95) begin
				add_packet(rand_hdr(16'(len)), len + 1, plan_opt ? TAIL_NONE : TAIL_GOOD, -1);
			end else begin
				add_raw($urandom_range(1, 12));
			end
		end

		stim_q.insert(stim_q.size(), '{kind: STIM_CALM, item: '0, opt: 1'b0});
		add_cfg(1'b1);
		repeat (6) begin
			len = $urandom_range(0, 12);
			add_packet(rand_hdr(16'(len)), len + 1, TAIL_GOOD, -1);
		end
		add_cfg(1'b0);
		add_packet(rand_hdr(16'd3), 4, TAIL_NONE, -1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (stim_q.size() != 0 || push || cfg_valid || want_q.size() != 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d buffer bytes with %0d trailer option writes; checked %0d payload %s",
			bytes_sent, opt_writes, payload_seen, "bytes.");
		$display("End records: ok %0d, short header %0d, short trailer %0d, CRC %s %0d, %s %0d.",
			status_hits[0], status_hits[1], status_hits[2], "mismatch", status_hits[3],
			"length mismatch", status_hits[4]);
		if (mismatches == 0 && want_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: space_packet_deframer_crc_check.f
design/spdf_pkg.sv
design/spdf_front.sv
design/spdf_queue.sv
design/spdf_back.sv
design/space_packet_deframer_crc_check.sv
sim/space_packet_deframer_crc_check_test.sv
